### design/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // Sector count of one hue turn and the bits that index it
    localparam int SECTOR_COUNT = 6;
    localparam int SECTOR_BITS  = 3;

    // Hue sector, the integer part of hue times six
    typedef enum logic [SECTOR_BITS-1:0] {
        SECT_RED_YEL = 3'd0,
        SECT_YEL_GRN = 3'd1,
        SECT_GRN_CYN = 3'd2,
        SECT_CYN_BLU = 3'd3,
        SECT_BLU_MAG = 3'd4,
        SECT_MAG_RED = 3'd5
    } sector_t;

endpackage

### design/hsv_pix_if.sv
// ----------------------------------------------------------------------------
// hsv_pix_if
// Valid/ready channel that carries one HSV pixel a beat.
// ----------------------------------------------------------------------------
interface hsv_pix_if #(
    parameter int FRAC_BITS = 16
) ();

    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS:0]   hue_turn;
    logic [FRAC_BITS:0]   sat_level;
    logic [FRAC_BITS:0]   val_level;

    modport source (output valid, output hue_turn, output sat_level, output val_level,
                    input ready);
    modport sink   (input valid, input hue_turn, input sat_level, input val_level,
                    output ready);

endinterface

### design/rgb_pix_if.sv
// ----------------------------------------------------------------------------
// rgb_pix_if
// Valid/ready channel that carries one RGB pixel a beat.
// ----------------------------------------------------------------------------
interface rgb_pix_if #(
    parameter int FRAC_BITS = 16
) ();

    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS:0]   red_level;
    logic [FRAC_BITS:0]   green_level;
    logic [FRAC_BITS:0]   blue_level;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, input ready);
    modport sink   (input valid, input red_level, input green_level,
                    input blue_level, output ready);

endinterface

### design/hsv_to_rgb_convert.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert
// Fixed-point HSV to RGB pixel converter, four register stages.
// ----------------------------------------------------------------------------
// Usage:
//   hsv : sink channel, one HSV pixel a beat (hue as a fraction of a turn,
//         saturation and value with 2^FRAC_BITS meaning 1.0).
//   rgb : source channel, one RGB pixel a beat, same fixed-point format.
//   Every input beat yields exactly one output beat, in order.
//   An accepted input beat passes stages 1 to 4 in order; rgb.valid is the stage 4 valid.
//   Throughput: one pixel per clock while rgb.ready stays high; each stage
//   holds one beat and takes a new one whenever it is empty or its own beat moves on.
//   Stages: 1 sector/fraction split and clamping, 2 s*f and s*(1-f) products,
//   3 value products, 4 sector selection into the output register.
//   The longest path is one multiplier of (FRAC_BITS+1) bits square.
//   Reset (rst_n low) empties all stages; no beat is in flight after it.
//   When the receiver holds rgb.ready low, the output beat is held stable
//   and the stages behind it keep filling until full; then hsv.ready drops.
//   Nothing is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    hsv_pix_if.sink    hsv,
    rgb_pix_if.source  rgb
);

    localparam int W  = FRAC_BITS + 1;
    localparam int W2 = 2 * W;
    localparam int HW = FRAC_BITS + hsv2rgb_pkg::SECTOR_BITS;
    localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Stage handshake
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4      = !vld4_reg || rgb.ready;
    assign rdy3      = !vld3_reg || rdy4;
    assign rdy2      = !vld2_reg || rdy3;
    assign rdy1      = !vld1_reg || rdy2;
    assign hsv.ready = rdy1;

    // Stage 1: clamp, hue times six, split into sector and fraction
    logic [FRAC_BITS-1:0]   hue_frac;
    logic [HW-1:0]          hue6;
    logic [W-1:0]           sat_clamp, val_clamp;
    logic [W-1:0]           sat1_reg, val1_reg;
    logic [FRAC_BITS-1:0]   frc1_reg;
    hsv2rgb_pkg::sector_t   sec1_reg;

    assign hue_frac  = hsv.hue_turn[FRAC_BITS-1:0];
    assign hue6      = (HW'(hue_frac) << 2) + (HW'(hue_frac) << 1);
    assign sat_clamp = hsv.sat_level[FRAC_BITS] ? ONE : hsv.sat_level;
    assign val_clamp = hsv.val_level[FRAC_BITS] ? ONE : hsv.val_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else if (rdy1)
        begin
            vld1_reg <= hsv.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && hsv.valid)
        begin
            sat1_reg <= sat_clamp;
            val1_reg <= val_clamp;
            frc1_reg <= hue6[FRAC_BITS-1:0];
            sec1_reg <= hsv2rgb_pkg::sector_t'(hue6[HW-1:FRAC_BITS]);
        end
    end

    // Stage 2: s*f and s*(1-f), then the one-minus terms
    logic [W-1:0]           one_m_f;
    logic [W2-1:0]          prod_sf, prod_st;
    logic [W-1:0]           qfac2_reg, tfac2_reg, pfac2_reg, val2_reg;
    hsv2rgb_pkg::sector_t   sec2_reg;

    assign one_m_f = ONE - W'(frc1_reg);
    assign prod_sf = W2'(sat1_reg) * W2'(frc1_reg);
    assign prod_st = W2'(sat1_reg) * W2'(one_m_f);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else if (rdy2)
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && vld1_reg)
        begin
            qfac2_reg <= ONE - prod_sf[FRAC_BITS +: W];
            tfac2_reg <= ONE - prod_st[FRAC_BITS +: W];
            pfac2_reg <= ONE - sat1_reg;
            val2_reg  <= val1_reg;
            sec2_reg  <= sec1_reg;
        end
    end

    // Stage 3: value products for p, q and t
    logic [W2-1:0]          pp3_reg, pq3_reg, pt3_reg;
    logic [W-1:0]           val3_reg;
    hsv2rgb_pkg::sector_t   sec3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
        end
        else if (rdy3)
        begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && vld2_reg)
        begin
            pp3_reg  <= W2'(val2_reg) * W2'(pfac2_reg);
            pq3_reg  <= W2'(val2_reg) * W2'(qfac2_reg);
            pt3_reg  <= W2'(val2_reg) * W2'(tfac2_reg);
            val3_reg <= val2_reg;
            sec3_reg <= sec2_reg;
        end
    end

    // Stage 4: truncate and order by sector; zero saturation falls out as grey
    logic [W-1:0] lvl_p, lvl_q, lvl_t;
    logic [W-1:0] red_next, green_next, blue_next;
    logic [W-1:0] red_reg, green_reg, blue_reg;

    assign lvl_p = pp3_reg[FRAC_BITS +: W];
    assign lvl_q = pq3_reg[FRAC_BITS +: W];
    assign lvl_t = pt3_reg[FRAC_BITS +: W];

    always_comb
    begin
        case (sec3_reg)
            hsv2rgb_pkg::SECT_RED_YEL:
            begin
                red_next = val3_reg; green_next = lvl_t;    blue_next = lvl_p;
            end
            hsv2rgb_pkg::SECT_YEL_GRN:
            begin
                red_next = lvl_q;    green_next = val3_reg; blue_next = lvl_p;
            end
            hsv2rgb_pkg::SECT_GRN_CYN:
            begin
                red_next = lvl_p;    green_next = val3_reg; blue_next = lvl_t;
            end
            hsv2rgb_pkg::SECT_CYN_BLU:
            begin
                red_next = lvl_p;    green_next = lvl_q;    blue_next = val3_reg;
            end
            hsv2rgb_pkg::SECT_BLU_MAG:
            begin
                red_next = lvl_t;    green_next = lvl_p;    blue_next = val3_reg;
            end
            default:
            begin
                red_next = val3_reg; green_next = lvl_p;    blue_next = lvl_q;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
        end
        else if (rdy4)
        begin
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && vld3_reg)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.valid       = vld4_reg;
    assign rgb.red_level   = red_reg;
    assign rgb.green_level = green_reg;
    assign rgb.blue_level  = blue_reg;

    // Checks
    logic [W:0] sf_sum, sat2_val;

    assign sf_sum   = (W+1)'(ONE - qfac2_reg) + (W+1)'(ONE - tfac2_reg);
    assign sat2_val = (W+1)'(ONE - pfac2_reg);

    // truncated s*f and s*(1-f) add up to s, or one short of it
    a_frac_split: assert property (@(posedge clk) disable iff (!rst_n)
        vld2_reg |-> (sf_sum == sat2_val || (sf_sum + 1'b1) == sat2_val))
        else $error("s*f + s*(1-f) does not match saturation");

    // clamped saturation and value never exceed one
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld1_reg |-> (sat1_reg <= ONE && val1_reg <= ONE))
        else $error("clamped input above one");

    // a beat in stage 1 that stage 2 takes shows up in stage 2
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (vld1_reg && rdy2) |=> vld2_reg)
        else $error("beat dropped between stage 1 and stage 2");

    // output components stay within one
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld4_reg |-> (red_reg <= ONE && green_reg <= ONE && blue_reg <= ONE))
        else $error("output component above one");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hsv_to_rgb_convert. It sends HSV pixels on the sink
// channel and predicts each RGB pixel in fixed point: sector split, truncated
// products and the sector-to-RGB order. Results are compared field by field,
// in order. It runs under several sender and receiver idle rates and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          FRAC_BITS   = 16;
    localparam logic [16:0] ONE_LEVEL   = 17'h10000;
    localparam logic [16:0] MAX_FIELD   = 17'h1FFFF;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PRINT_LIMIT = 40;

    typedef struct packed {
        logic [FRAC_BITS:0] hue;
        logic [FRAC_BITS:0] sat;
        logic [FRAC_BITS:0] val;
    } hsv_pix_t;

    typedef struct packed {
        logic [FRAC_BITS:0] red;
        logic [FRAC_BITS:0] green;
        logic [FRAC_BITS:0] blue;
    } rgb_pix_t;

    logic clk;
    logic rst_n;

    hsv_pix_if #(.FRAC_BITS(FRAC_BITS)) hsv_bus ();
    rgb_pix_if #(.FRAC_BITS(FRAC_BITS)) rgb_bus ();

    hsv_to_rgb_convert #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsv   (hsv_bus),
        .rgb   (rgb_bus)
    );

    // Pending RGB pixels, oldest first
    rgb_pix_t expected_rgb[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_req   = 0;
    int pixels_sent    = 0;
    int pixels_checked = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // ------------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------------
    // Truncated Q1.16 product; both operands are at most 1.0
    function automatic logic [16:0] scale_level(input logic [16:0] a,
                                                input logic [16:0] b);
        logic [33:0] prod;
        prod = a * b;
        return prod[32:16];
    endfunction

    function automatic rgb_pix_t convert_pixel(input hsv_pix_t px);
        logic [15:0]          hue_frac;
        logic [18:0]          hue_x6;
        logic [16:0]          frac;
        logic [16:0]          s;
        logic [16:0]          v;
        logic [16:0]          p;
        logic [16:0]          q;
        logic [16:0]          t;
        hsv2rgb_pkg::sector_t sect;
        rgb_pix_t             res;
        // full turn and anything above it wrap to the low bits
        hue_frac = px.hue[15:0];
        s        = (px.sat > ONE_LEVEL) ? ONE_LEVEL : px.sat;
        v        = (px.val > ONE_LEVEL) ? ONE_LEVEL : px.val;
        hue_x6   = 19'(hue_frac) * 19'd6;
        sect     = hsv2rgb_pkg::sector_t'(hue_x6[18:16]);
        frac     = {1'b0, hue_x6[15:0]};
        p        = scale_level(v, ONE_LEVEL - s);
        q        = scale_level(v, ONE_LEVEL - scale_level(s, frac));
        t        = scale_level(v, ONE_LEVEL - scale_level(s, ONE_LEVEL - frac));
        if (s == '0)
        begin
            res = '{v, v, v};
        end
        else
        begin
            case (sect)
                hsv2rgb_pkg::SECT_RED_YEL: res = '{v, t, p};
                hsv2rgb_pkg::SECT_YEL_GRN: res = '{q, v, p};
                hsv2rgb_pkg::SECT_GRN_CYN: res = '{p, v, t};
                hsv2rgb_pkg::SECT_CYN_BLU: res = '{p, q, v};
                hsv2rgb_pkg::SECT_BLU_MAG: res = '{t, p, v};
                default:                   res = '{v, p, q};
            endcase
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results pending",
                         cycle_count, expected_rgb.size());
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls plus requested hold-off stretches
    // ------------------------------------------------------------------------
    initial
    begin
        rgb_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req > 0)
            begin
                rgb_bus.ready <= 1'b0;
                hold_off_req--;
            end
            else
            begin
                rgb_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [16:0] got,
                                   input logic [16:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH beat %0d: %s got %05h want %05h",
                     pixels_checked, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_rgb
        rgb_pix_t want;
        if (rst_n && rgb_bus.valid && rgb_bus.ready)
        begin
            if (expected_rgb.size() == 0)
            begin
                report_mismatch("unexpected beat, red", rgb_bus.red_level, '0);
            end
            else
            begin
                want = expected_rgb.pop_front();
                if (rgb_bus.red_level !== want.red)
                    report_mismatch("red", rgb_bus.red_level, want.red);
                if (rgb_bus.green_level !== want.green)
                    report_mismatch("green", rgb_bus.green_level, want.green);
                if (rgb_bus.blue_level !== want.blue)
                    report_mismatch("blue", rgb_bus.blue_level, want.blue);
            end
            pixels_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Sender: entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_pixel(input hsv_pix_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            hsv_bus.valid <= 1'b0;
            @(negedge clk);
        end
        hsv_bus.valid     <= 1'b1;
        hsv_bus.hue_turn  <= px.hue;
        hsv_bus.sat_level <= px.sat;
        hsv_bus.val_level <= px.val;
        do
            @(posedge clk);
        while (!hsv_bus.ready);
        expected_rgb.push_back(convert_pixel(px));
        pixels_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain_results();
        hsv_bus.valid <= 1'b0;
        @(negedge clk);
        while (expected_rgb.size() != 0)
            @(negedge clk);
    endtask

    // Mostly in range, with a share of zero, full scale and over-range values
    function automatic logic [16:0] pick_level();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return ONE_LEVEL;
        else if (r < 22)
            return 17'($urandom_range(ONE_LEVEL + 1, MAX_FIELD));
        else
            return 17'($urandom_range(0, ONE_LEVEL));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        hsv_pix_t cases[$];
        cases = '{
            '{17'd0,     17'd0,     17'd0},        // all zero
            '{17'd0,     17'd0,     ONE_LEVEL},    // white, grey path
            '{17'd21000, 17'd0,     17'd30000},    // grey at arbitrary hue
            '{17'd0,     ONE_LEVEL, ONE_LEVEL},    // pure red
            '{ONE_LEVEL, ONE_LEVEL, ONE_LEVEL},    // full turn acts as hue zero
            '{MAX_FIELD, ONE_LEVEL, ONE_LEVEL},    // hue past a turn wraps
            '{17'h18000, ONE_LEVEL, 17'd40000},    // wraps to half a turn
            '{17'd10922, ONE_LEVEL, ONE_LEVEL},    // end of first sector
            '{17'd10923, ONE_LEVEL, ONE_LEVEL},    // start of second sector
            '{17'd21846, 17'd50000, ONE_LEVEL},
            '{17'd32768, ONE_LEVEL, 17'd65535},    // sector boundary, f = 0
            '{17'd43691, 17'd30000, 17'd60000},
            '{17'd54614, ONE_LEVEL, ONE_LEVEL},
            '{17'd65535, ONE_LEVEL, ONE_LEVEL},    // top of last sector
            '{17'd5461,  17'd32768, 17'd50000},
            '{17'd27307, MAX_FIELD, MAX_FIELD},    // saturation and value clamp
            '{17'd40000, 17'h10001, 17'd12345},
            '{17'd60000, 17'd1,     ONE_LEVEL},    // tiny saturation
            '{17'd16384, 17'd65535, 17'd65535},
            '{17'd49152, ONE_LEVEL, 17'd1},
            '{17'h0AAAA, 17'h15555, 17'h0AAAA},    // alternating bit patterns
            '{17'h15555, 17'h0AAAA, 17'h15555}
        };
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (cases[i])
            send_pixel(cases[i]);
        drain_results();
    endtask

    task automatic test_random(input int send_pct, input int recv_pct,
                               input int count);
        hsv_pix_t px;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
        begin
            px.hue = ($urandom_range(9) == 0) ? 17'($urandom_range(0, MAX_FIELD))
                                              : 17'($urandom_range(0, ONE_LEVEL));
            px.sat = pick_level();
            px.val = pick_level();
            send_pixel(px);
        end
        drain_results();
    endtask

    // Receiver holds off long enough for every stage to fill and stall input
    task automatic test_backpressure(input int count);
        hsv_pix_t px;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 60;
        repeat (count)
        begin
            px = '{17'($urandom_range(0, MAX_FIELD)), pick_level(), pick_level()};
            send_pixel(px);
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        hsv_bus.valid     = 1'b0;
        hsv_bus.hue_turn  = '0;
        hsv_bus.sat_level = '0;
        hsv_bus.val_level = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(0, 0, 200);
        test_random(58, 0, 160);
        test_random(0, 58, 160);
        test_random(12, 12, 160);
        test_backpressure(80);
        test_random(0, 0, 40);

        // catch any stray beat after the last expected one
        repeat (12) @(posedge clk);

        $display("sent %0d HSV pixels, checked %0d RGB pixels, %0d mismatches",
                 pixels_sent, pixels_checked, mismatch_count);
        $display("covered grey, all six sectors, hue wrap, clamping, stalls and hold-off");
        if (mismatch_count == 0 && expected_rgb.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
